FILE: rtl/tdq_pkg.sv
`timescale 1ns / 1ps

package tdq_pkg;

  localparam int TIMER_SLOTS = 8;
  localparam int SLOT_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int MAX_FIRE    = 8;
  localparam int FIRE_W      = $clog2(MAX_FIRE + 1);
  // the scan covers the due flags and the token's walk through every cell
  localparam int SCAN_LEN    = TIMER_SLOTS + 1;
  localparam int CNT_W       = $clog2(SCAN_LEN + 1);

  typedef enum logic [1:0] {
    OP_ARM    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_TICK   = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_ARM    = 2'd0,
    KIND_CANCEL = 2'd1,
    KIND_TIME   = 2'd2,
    KIND_EXPIRY = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_PER_ABS  = 2'd1,
    STAT_ZERO_PER = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    MODE_CANCELLED = 2'd0,
    MODE_ONESHOT   = 2'd1,
    MODE_PERIODIC  = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_CANCEL  = 3'd1,
    CMD_ARM_ONE = 3'd2,
    CMD_ARM_PER = 3'd3,
    CMD_FIRE    = 3'd4
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t             op;
    logic [SLOT_W-1:0]   idx;
    logic [63:0]         deadline;
    logic [63:0]         period;
    logic [63:0]         stamp;
  } cmd_t;

  typedef struct packed {
    logic                valid;
    logic                periodic;
    logic [63:0]         deadline;
    logic [63:0]         stamp;
    logic [SLOT_W-1:0]   slot;
  } tok_t;

endpackage

FILE: rtl/tdq_cell.sv
`timescale 1ns / 1ps

module tdq_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [tdq_pkg::SLOT_W-1:0] idx,
  input  logic [63:0]               now,
  input  tdq_pkg::cmd_t             cmd,
  input  tdq_pkg::tok_t             tok_in,
  output tdq_pkg::tok_t             tok_out
);

  tdq_pkg::mode_t mode;
  logic [63:0]    deadline;
  logic [63:0]    period;
  logic [63:0]    stamp;
  logic           due;
  logic           hit;
  logic           better;

  assign hit = (cmd.idx == idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= tdq_pkg::MODE_CANCELLED;
    end else if (hit) begin
      case (cmd.op)
        tdq_pkg::CMD_CANCEL: begin
          mode <= tdq_pkg::MODE_CANCELLED;
        end
        tdq_pkg::CMD_ARM_ONE: begin
          mode <= tdq_pkg::MODE_ONESHOT;
        end
        tdq_pkg::CMD_ARM_PER: begin
          mode <= tdq_pkg::MODE_PERIODIC;
        end
        tdq_pkg::CMD_FIRE: begin
          if (mode != tdq_pkg::MODE_PERIODIC) begin
            mode <= tdq_pkg::MODE_CANCELLED;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      case (cmd.op)
        tdq_pkg::CMD_ARM_ONE: begin
          deadline <= cmd.deadline;
          stamp    <= cmd.stamp;
        end
        tdq_pkg::CMD_ARM_PER: begin
          deadline <= cmd.deadline;
          period   <= cmd.period;
          stamp    <= cmd.stamp;
        end
        tdq_pkg::CMD_FIRE: begin
          if (mode == tdq_pkg::MODE_PERIODIC) begin
            deadline <= deadline + period;
            stamp    <= cmd.stamp;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      due <= 1'b0;
    end else begin
      due <= (mode != tdq_pkg::MODE_CANCELLED) && (deadline <= now);
    end
  end

  // ties keep the incoming (lower index) token
  assign better = due && (!tok_in.valid || (deadline < tok_in.deadline) ||
                  ((deadline == tok_in.deadline) && (stamp < tok_in.stamp)));

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else if (better) begin
      tok_out.valid    <= 1'b1;
      tok_out.periodic <= (mode == tdq_pkg::MODE_PERIODIC);
      tok_out.deadline <= deadline;
      tok_out.stamp    <= stamp;
      tok_out.slot     <= idx;
    end else begin
      tok_out <= tok_in;
    end
  end

endmodule

FILE: rtl/timer_deadline_queue_top.sv
`timescale 1ns / 1ps
// Arm, cancel and read: the reply word is valid in the cycle after acceptance.
// Tick: a firing round registers due flags, then the token walks the cell chain;
// up to eight rounds fire (a tick with fewer ends on a round with no due slot),
// then the flush state queues the last expiry. Next word is taken once the tick's
// last expiry is queued. Reset clears time, arm counter, slot modes, out_valid.
module timer_deadline_queue_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [2:0]  slot,
  input  logic [63:0] time_value,
  input  logic        absolute_flag,
  input  logic        periodic_flag,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [2:0]  fired_slot,
  output logic [63:0] time_out,
  output logic [1:0]  status,
  output logic        last
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  state_t                      state, state_next;
  logic [63:0]                 now_counter, now_counter_next;
  logic [63:0]                 arm_counter, arm_counter_next;
  logic [tdq_pkg::CNT_W-1:0]   cnt, cnt_next;
  logic [tdq_pkg::FIRE_W-1:0]  fired, fired_next;
  logic                        pend_valid, pend_valid_next;
  logic [tdq_pkg::SLOT_W-1:0]  pend_slot, pend_slot_next;
  logic [63:0]                 pend_time, pend_time_next;

  tdq_pkg::cmd_t               cmd;
  tdq_pkg::tok_t               chain_in [tdq_pkg::TIMER_SLOTS];
  tdq_pkg::tok_t               tok      [tdq_pkg::TIMER_SLOTS];
  tdq_pkg::tok_t               best;

  logic        in_acc;
  logic        out_free;
  logic        slot_ok;
  logic [63:0] arm_time;
  logic        o_load;
  logic [1:0]  o_kind;
  logic [2:0]  o_slot;
  logic [63:0] o_time;
  logic [1:0]  o_status;
  logic        o_last;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = !((state == ST_IDLE) && out_free);
  assign in_acc   = in_valid && !in_stall;
  assign slot_ok  = (32'(slot) < 32'(tdq_pkg::TIMER_SLOTS));
  assign arm_time = absolute_flag ? time_value : time_value + now_counter;
  assign best     = tok[tdq_pkg::TIMER_SLOTS-1];

  assign chain_in[0] = '0;
  for (genvar i = 1; i < tdq_pkg::TIMER_SLOTS; i++) begin : g_link
    assign chain_in[i] = tok[i-1];
  end

  for (genvar i = 0; i < tdq_pkg::TIMER_SLOTS; i++) begin : g_cell
    tdq_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .idx     (tdq_pkg::SLOT_W'(i)),
      .now     (now_counter),
      .cmd     (cmd),
      .tok_in  (chain_in[i]),
      .tok_out (tok[i])
    );
  end

  always_comb begin
    state_next       = state;
    now_counter_next = now_counter;
    arm_counter_next = arm_counter;
    cnt_next         = cnt;
    fired_next       = fired;
    pend_valid_next  = pend_valid;
    pend_slot_next   = pend_slot;
    pend_time_next   = pend_time;
    cmd.op           = tdq_pkg::CMD_NONE;
    cmd.idx          = tdq_pkg::SLOT_W'(slot);
    cmd.deadline     = arm_time;
    cmd.period       = time_value;
    cmd.stamp        = arm_counter;
    o_load           = 1'b0;
    o_kind           = tdq_pkg::KIND_EXPIRY;
    o_slot           = 3'(pend_slot);
    o_time           = pend_time;
    o_status         = tdq_pkg::STAT_OK;
    o_last           = 1'b1;

    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          case (operation)
            tdq_pkg::OP_TICK: begin
              now_counter_next = now_counter + 64'd1;
              cnt_next         = '0;
              fired_next       = '0;
              pend_valid_next  = 1'b0;
              state_next       = ST_SCAN;
            end
            tdq_pkg::OP_READ: begin
              o_load = 1'b1;
              o_kind = tdq_pkg::KIND_TIME;
              o_slot = 3'd0;
              o_time = now_counter;
            end
            tdq_pkg::OP_CANCEL: begin
              o_load = 1'b1;
              o_kind = tdq_pkg::KIND_CANCEL;
              o_slot = slot;
              o_time = '0;
              if (slot_ok) begin
                cmd.op = tdq_pkg::CMD_CANCEL;
              end
            end
            default: begin
              o_load = 1'b1;
              o_kind = tdq_pkg::KIND_ARM;
              o_slot = slot;
              o_time = '0;
              if (slot_ok) begin
                if (periodic_flag && absolute_flag) begin
                  cmd.op   = tdq_pkg::CMD_CANCEL;
                  o_status = tdq_pkg::STAT_PER_ABS;
                end else if (periodic_flag && (time_value == 64'd0)) begin
                  cmd.op   = tdq_pkg::CMD_CANCEL;
                  o_status = tdq_pkg::STAT_ZERO_PER;
                end else begin
                  cmd.op = periodic_flag ? tdq_pkg::CMD_ARM_PER : tdq_pkg::CMD_ARM_ONE;
                  o_time = arm_time;
                  arm_counter_next = arm_counter + 64'd1;
                end
              end
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (cnt != tdq_pkg::CNT_W'(tdq_pkg::SCAN_LEN)) begin
          cnt_next = cnt + tdq_pkg::CNT_W'(1);
        end else if (out_free) begin
          if (best.valid) begin
            cmd.op  = tdq_pkg::CMD_FIRE;
            cmd.idx = best.slot;
            if (best.periodic) begin
              arm_counter_next = arm_counter + 64'd1;
            end
            o_load          = pend_valid;
            o_last          = 1'b0;
            pend_valid_next = 1'b1;
            pend_slot_next  = best.slot;
            pend_time_next  = best.deadline;
            fired_next      = fired + tdq_pkg::FIRE_W'(1);
            cnt_next        = '0;
            if (fired_next == tdq_pkg::FIRE_W'(tdq_pkg::MAX_FIRE)) begin
              state_next = ST_FLUSH;
            end
          end else begin
            state_next = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          o_load          = pend_valid;
          pend_valid_next = 1'b0;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      now_counter <= '0;
      arm_counter <= '0;
      cnt         <= '0;
      fired       <= '0;
      pend_valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      now_counter <= now_counter_next;
      arm_counter <= arm_counter_next;
      cnt         <= cnt_next;
      fired       <= fired_next;
      pend_valid  <= pend_valid_next;
      out_valid   <= o_load || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    pend_slot <= pend_slot_next;
    pend_time <= pend_time_next;
    if (o_load) begin
      kind       <= o_kind;
      fired_slot <= o_slot;
      time_out   <= o_time;
      status     <= o_status;
      last       <= o_last;
    end
  end

  a_reply_next: assert property (@(posedge clk) disable iff (rst)
    (in_acc && (operation != tdq_pkg::OP_TICK)) |=> out_valid)
    else $error("reply word not registered after request");

  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> in_stall)
    else $error("input taken while a tick is in progress");

  a_only_expiry_open: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> (kind == tdq_pkg::KIND_EXPIRY))
    else $error("non-final word that is not an expiry");

  a_now_holds: assert property (@(posedge clk) disable iff (rst)
    !(in_acc && (operation == tdq_pkg::OP_TICK)) |=> (now_counter == $past(now_counter)))
    else $error("time changed without a tick");

  a_fire_cap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (fired < tdq_pkg::FIRE_W'(tdq_pkg::MAX_FIRE)))
    else $error("scan running past the firing limit");

endmodule
